// ----- src/arpre_pkg.sv -----
// Package for the ARP request/reply engine: item structs, result and opcode
// codes, register indexes and fixed address constants. No dependencies.
package arpre_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_IP    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_MAC   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROTO     = 2'd2;

   localparam logic [1:0] KIND_BIND  = 2'd0;
   localparam logic [1:0] KIND_REQ   = 2'd1;
   localparam logic [1:0] KIND_REPLY = 2'd2;
   localparam logic [1:0] KIND_ALARM = 2'd3;

   localparam logic [1:0]  OP_NONE      = 2'd0;
   localparam logic [1:0]  OP_REQUEST   = 2'd1;
   localparam logic [1:0]  OP_REPLY     = 2'd2;
   localparam logic [15:0] OPCODE_REQ16 = 16'd1;

   localparam logic       ITEM_LOOKUP = 1'b0;

   localparam logic [31:0] SUBNET_MASK     = 32'hffff_ff00;
   localparam logic [47:0] BCAST_MAC       = 48'hffff_ffff_ffff;
   localparam logic [15:0] PROTO_RESET     = 16'h0800;

   typedef struct packed {
      logic        operation;
      logic [31:0] lookup_ip;
      logic [15:0] arp_protocol;
      logic [15:0] arp_opcode_in;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] target_ip_in;
      logic [47:0] frame_source_mac;
   } arpre_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] bind_ip;
      logic [47:0] bind_mac;
      logic [1:0]  out_opcode;
      logic [31:0] out_target_ip;
      logic [47:0] out_target_mac;
      logic [47:0] alarm_mac;
      logic        last_result;
   } arpre_rsp_type;

endpackage

// ----- src/arp_request_reply_engine.sv -----
// ARP request/reply engine top level: input register, decision logic,
// result register and a one-deep hold for the reply. Uses arpre_pkg.
//
//   channel  ports                          handshake
//   req      start, busy, req_data          taken when start && !busy
//   rsp      rsp_valid, rsp_data            one-cycle strobe, no backpressure
//   csr      csr_wr_en, csr_index, csr_wdata written when csr_wr_en
//
// A taken item is held in the input register, and its first result is then
// registered in the result register. One item can be taken every cycle; an
// item that yields a binding plus a reply holds busy for one cycle while the
// reply is loaded into the hold register, and busy keeps a new item out.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// Results cannot be stalled by the receiver.
module arp_request_reply_engine (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  arpre_pkg::arpre_req_type                req_data,
   output logic                                    rsp_valid,
   output arpre_pkg::arpre_rsp_type                rsp_data,
   input  logic                                    csr_wr_en,
   input  logic [arpre_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [arpre_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import arpre_pkg::*;

   logic [31:0]   own_ip_ff, own_ip_in;
   logic [47:0]   own_mac_ff, own_mac_in;
   logic [15:0]   proto_ff, proto_in;

   logic          s1_valid_ff, s1_valid_in;
   arpre_req_type s1_data_ff, s1_data_in;
   logic          pend_ff, pend_in;
   arpre_rsp_type pend_data_ff, pend_data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   arpre_rsp_type rsp_data_ff, rsp_data_in;

   arpre_rsp_type first_res, second_res;
   logic          first_ok;
   logic          two_res;
   logic          take;
   logic          proto_match, forged, want_reply;

   always_comb begin
      proto_match = (s1_data_ff.arp_protocol == proto_ff);
      forged      = (s1_data_ff.sender_mac != own_mac_ff) &&
                    (s1_data_ff.sender_ip == own_ip_ff);
      want_reply  = (s1_data_ff.arp_opcode_in == OPCODE_REQ16) &&
                    (s1_data_ff.target_ip_in == own_ip_ff);

      first_res  = '0;
      second_res = '0;
      first_ok   = 1'b0;
      two_res    = 1'b0;

      second_res.result_kind    = KIND_REPLY;
      second_res.out_opcode     = OP_REPLY;
      second_res.out_target_ip  = s1_data_ff.sender_ip;
      second_res.out_target_mac = s1_data_ff.sender_mac;
      second_res.last_result    = 1'b1;

      first_res.last_result = 1'b1;
      if (s1_data_ff.operation == ITEM_LOOKUP) begin
         first_ok = 1'b1;
         if (s1_data_ff.lookup_ip == (own_ip_ff & SUBNET_MASK)) begin
            first_res.result_kind = KIND_BIND;
            first_res.bind_ip     = s1_data_ff.lookup_ip;
            first_res.bind_mac    = BCAST_MAC;
         end else if (s1_data_ff.lookup_ip == own_ip_ff) begin
            first_res.result_kind = KIND_BIND;
            first_res.bind_ip     = s1_data_ff.lookup_ip;
            first_res.bind_mac    = own_mac_ff;
         end else begin
            first_res.result_kind   = KIND_REQ;
            first_res.out_opcode    = OP_REQUEST;
            first_res.out_target_ip = s1_data_ff.lookup_ip;
         end
      end else if (proto_match) begin
         first_ok = 1'b1;
         if (forged) begin
            first_res.result_kind = KIND_ALARM;
            first_res.alarm_mac   = s1_data_ff.frame_source_mac;
         end else begin
            first_res.result_kind = KIND_BIND;
            first_res.bind_ip     = s1_data_ff.sender_ip;
            first_res.bind_mac    = s1_data_ff.sender_mac;
            first_res.last_result = !want_reply;
            two_res               = want_reply;
         end
      end
   end

   // no new item enters while a two-result item is being split
   assign busy = s1_valid_ff && two_res;
   assign take = start && !busy;

   always_comb begin
      own_ip_in  = own_ip_ff;
      own_mac_in = own_mac_ff;
      proto_in   = proto_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_OWN_IP:  own_ip_in  = csr_wdata[31:0];
            CSR_OWN_MAC: own_mac_in = csr_wdata[47:0];
            CSR_PROTO:   proto_in   = csr_wdata[15:0];
            default:     ;
         endcase
      end

      s1_valid_in = take;
      s1_data_in  = take ? req_data : s1_data_ff;

      pend_in      = s1_valid_ff && two_res;
      pend_data_in = second_res;

      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_data_ff;
      end else begin
         rsp_valid_in = s1_valid_ff && first_ok;
         rsp_data_in  = first_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff    <= '0;
         own_mac_ff   <= '0;
         proto_ff     <= PROTO_RESET;
         s1_valid_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         own_ip_ff    <= own_ip_in;
         own_mac_ff   <= own_mac_in;
         proto_ff     <= proto_in;
         s1_valid_ff  <= s1_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff   <= s1_data_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !s1_valid_ff)
      else $error("held reply collides with a new item");

   a_split_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && two_res) |=> pend_ff)
      else $error("second result not held");

   a_hold_once: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("hold register stuck");

   a_hold_emits: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> (rsp_valid_ff && rsp_data_ff.result_kind == KIND_REPLY))
      else $error("held reply not emitted");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last_result) |=>
         (rsp_valid_ff && rsp_data_ff.last_result))
      else $error("final result missing after non-final one");
`endif

endmodule

// ----- verif/tb_arp_request_reply_engine.sv -----
// Testbench for arp_request_reply_engine: directed and random items, results
// predicted in-bench and checked in order. Needs arpre_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb_arp_request_reply_engine;
   import arpre_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SEGMENT_ITEMS = 50;
   localparam int SEGMENTS_PER_PHASE = 7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   arpre_req_type req_data = '0;
   logic rsp_valid;
   arpre_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [31:0] cfg_own_ip = 32'h0;
   logic [47:0] cfg_own_mac = 48'h0;
   logic [15:0] cfg_proto = PROTO_RESET;

   arpre_rsp_type pending_results[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int items_sent = 0;
   int dropped_count = 0;
   int kind_tally[4] = '{0, 0, 0, 0};

   arp_request_reply_engine dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   function automatic arpre_req_type rand_req();
      logic [255:0] bits;
      bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom()};
      return bits[$bits(arpre_req_type)-1:0];
   endfunction

   function automatic string rsp_text(input arpre_rsp_type r);
      return $sformatf("kind=%0d bip=%h bmac=%h op=%0d tip=%h tmac=%h amac=%h last=%b",
                       r.result_kind, r.bind_ip, r.bind_mac, r.out_opcode,
                       r.out_target_ip, r.out_target_mac, r.alarm_mac, r.last_result);
   endfunction

   // expected results of one item, queued in arrival order
   function automatic void resolve_item(input arpre_req_type it);
      arpre_rsp_type r;
      logic answer;
      r = '0;
      if (it.operation == ITEM_LOOKUP) begin
         r.last_result = 1'b1;
         if (it.lookup_ip == (cfg_own_ip & SUBNET_MASK)) begin
            r.result_kind = KIND_BIND;
            r.bind_ip = it.lookup_ip;
            r.bind_mac = BCAST_MAC;
         end else if (it.lookup_ip == cfg_own_ip) begin
            r.result_kind = KIND_BIND;
            r.bind_ip = it.lookup_ip;
            r.bind_mac = cfg_own_mac;
         end else begin
            r.result_kind = KIND_REQ;
            r.out_opcode = OP_REQUEST;
            r.out_target_ip = it.lookup_ip;
         end
         pending_results.push_back(r);
         kind_tally[r.result_kind]++;
      end else if (it.arp_protocol != cfg_proto) begin
         dropped_count++;
      end else if (it.sender_mac != cfg_own_mac && it.sender_ip == cfg_own_ip) begin
         r.result_kind = KIND_ALARM;
         r.alarm_mac = it.frame_source_mac;
         r.last_result = 1'b1;
         pending_results.push_back(r);
         kind_tally[KIND_ALARM]++;
      end else begin
         answer = (it.arp_opcode_in == OPCODE_REQ16) && (it.target_ip_in == cfg_own_ip);
         r.result_kind = KIND_BIND;
         r.bind_ip = it.sender_ip;
         r.bind_mac = it.sender_mac;
         r.last_result = !answer;
         pending_results.push_back(r);
         kind_tally[KIND_BIND]++;
         if (answer) begin
            r = '0;
            r.result_kind = KIND_REPLY;
            r.out_opcode = OP_REPLY;
            r.out_target_ip = it.sender_ip;
            r.out_target_mac = it.sender_mac;
            r.last_result = 1'b1;
            pending_results.push_back(r);
            kind_tally[KIND_REPLY]++;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input arpre_rsp_type want,
                                  input arpre_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, what);
         $display("   expected %s", rsp_text(want));
         $display("   actual   %s", rsp_text(got));
      end
   endtask

   always @(posedge clock) begin : check_results
      arpre_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no item outstanding", '0, rsp_data);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_kind !== want.result_kind ||
                rsp_data.bind_ip !== want.bind_ip ||
                rsp_data.bind_mac !== want.bind_mac ||
                rsp_data.out_opcode !== want.out_opcode ||
                rsp_data.out_target_ip !== want.out_target_ip ||
                rsp_data.out_target_mac !== want.out_target_mac ||
                rsp_data.alarm_mac !== want.alarm_mac ||
                rsp_data.last_result !== want.last_result) begin
               report_mismatch("result mismatch", want, rsp_data);
            end
         end
      end
   end

   // leaves start high after acceptance; the caller lowers it or sends again
   task automatic send_item(input arpre_req_type it);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      resolve_item(it);
      items_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_reg(input logic [CSR_INDEX_W-1:0] index,
                              input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_OWN_IP: cfg_own_ip = value[31:0];
         CSR_OWN_MAC: cfg_own_mac = value[47:0];
         CSR_PROTO: cfg_proto = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_addresses(input logic [31:0] ip, input logic [47:0] mac,
                                input logic [15:0] proto);
      program_reg(CSR_OWN_IP, {16'h0, ip});
      program_reg(CSR_OWN_MAC, mac);
      program_reg(CSR_PROTO, {32'h0, proto});
   endtask

   function automatic arpre_req_type lookup_item(input logic [31:0] ip);
      arpre_req_type it;
      it = rand_req();
      it.operation = ITEM_LOOKUP;
      it.lookup_ip = ip;
      return it;
   endfunction

   function automatic arpre_req_type arp_packet(input logic [15:0] proto,
                                                input logic [15:0] opcode,
                                                input logic [47:0] smac,
                                                input logic [31:0] sip,
                                                input logic [31:0] tip,
                                                input logic [47:0] fsrc);
      arpre_req_type it;
      it.operation = !ITEM_LOOKUP;
      it.lookup_ip = $urandom();
      it.arp_protocol = proto;
      it.arp_opcode_in = opcode;
      it.sender_mac = smac;
      it.sender_ip = sip;
      it.target_ip_in = tip;
      it.frame_source_mac = fsrc;
      return it;
   endfunction

   task automatic test_reset_defaults();
      send_item(lookup_item(32'h0));
      send_item(lookup_item(32'h0000_0001));
      send_item(arp_packet(PROTO_RESET, OPCODE_REQ16, 48'h0, 32'h0, 32'h0, rand48()));
      wait_idle();
   endtask

   task automatic test_lookup_resolution();
      set_addresses(32'hc0a8_0137, 48'h0123_4567_89ab, PROTO_RESET);
      send_item(lookup_item(32'hc0a8_0100));
      send_item(lookup_item(32'hc0a8_0137));
      send_item(lookup_item(32'hffff_ffff));
      send_item(lookup_item(32'h0));
      wait_idle();
      program_reg(CSR_UNUSED, 48'hffff_ffff_ffff);
      send_item(lookup_item(32'hc0a8_0137));
      wait_idle();
      // own address is its own subnet base
      program_reg(CSR_OWN_IP, 48'h0a00_0000);
      send_item(lookup_item(32'h0a00_0000));
      wait_idle();
      program_reg(CSR_OWN_IP, 48'hffff_ffff);
      send_item(lookup_item(32'hffff_ff00));
      send_item(lookup_item(32'hffff_ffff));
      wait_idle();
   endtask

   task automatic test_arp_packets();
      logic [31:0] me;
      logic [47:0] peer;
      me = 32'hc0a8_0137;
      peer = 48'h5a5a_a5a5_0f0f;
      set_addresses(me, 48'hffff_ffff_ffff, PROTO_RESET);
      send_item(arp_packet(16'h86dd, OPCODE_REQ16, peer, 32'hc0a8_0101, me, peer));
      send_item(arp_packet(PROTO_RESET, OPCODE_REQ16, 48'h0, me, me, 48'hffff_ffff_ffff));
      send_item(arp_packet(PROTO_RESET, OPCODE_REQ16, 48'hffff_ffff_ffff, me, me, peer));
      send_item(arp_packet(PROTO_RESET, OPCODE_REQ16, peer, 32'hc0a8_0101, me, 48'h0));
      send_item(arp_packet(PROTO_RESET, OPCODE_REQ16, peer, 32'h0, 32'hc0a8_0138, peer));
      send_item(arp_packet(PROTO_RESET, 16'd2, peer, 32'hffff_ffff, me, peer));
      send_item(arp_packet(PROTO_RESET, 16'hffff, 48'h0, 32'hc0a8_0102, me, peer));
      send_item(arp_packet(PROTO_RESET, 16'h0, peer, 32'hc0a8_0103, me, peer));
      wait_idle();
      program_reg(CSR_PROTO, 48'hffff);
      send_item(arp_packet(16'hffff, OPCODE_REQ16, peer, 32'hc0a8_0104, me, peer));
      send_item(arp_packet(PROTO_RESET, OPCODE_REQ16, peer, 32'hc0a8_0105, me, peer));
      wait_idle();
      program_reg(CSR_PROTO, 48'h0);
      send_item(arp_packet(16'h0, OPCODE_REQ16, peer, 32'hc0a8_0106, me, peer));
      wait_idle();
   endtask

   task automatic random_settings();
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] proto;
      case ($urandom_range(5))
         0: ip = 32'h0;
         1: ip = 32'hffff_ffff;
         2: ip = {24'($urandom()), 8'h00};
         default: ip = $urandom();
      endcase
      case ($urandom_range(3))
         0: mac = 48'h0;
         1: mac = 48'hffff_ffff_ffff;
         default: mac = rand48();
      endcase
      case ($urandom_range(5))
         0: proto = 16'h0;
         1: proto = 16'hffff;
         2: proto = 16'($urandom());
         default: proto = PROTO_RESET;
      endcase
      set_addresses(ip, mac, proto);
      if ($urandom_range(3) == 0) program_reg(CSR_UNUSED, rand48());
   endtask

   // mostly well-formed traffic aimed at the configured addresses
   function automatic arpre_req_type random_item();
      arpre_req_type it;
      it = rand_req();
      if (it.operation == ITEM_LOOKUP) begin
         case ($urandom_range(9))
            0, 1, 2: it.lookup_ip = cfg_own_ip & SUBNET_MASK;
            3, 4: it.lookup_ip = cfg_own_ip;
            5, 6: it.lookup_ip = {cfg_own_ip[31:8], it.lookup_ip[7:0]};
            default: ;
         endcase
      end else begin
         if ($urandom_range(9) < 8) it.arp_protocol = cfg_proto;
         case ($urandom_range(3))
            0, 1: it.arp_opcode_in = OPCODE_REQ16;
            2: it.arp_opcode_in = 16'd2;
            default: ;
         endcase
         if ($urandom_range(3) == 0) it.sender_ip = cfg_own_ip;
         if ($urandom_range(9) < 3) it.sender_mac = cfg_own_mac;
         if ($urandom_range(9) < 6) it.target_ip_in = cfg_own_ip;
      end
      return it;
   endfunction

   task automatic test_random_traffic(input int idle_pct);
      sender_idle_pct = idle_pct;
      for (int s = 0; s < SEGMENTS_PER_PHASE; s++) begin
         random_settings();
         for (int n = 0; n < SEGMENT_ITEMS; n++) send_item(random_item());
         wait_idle();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 9;
      test_reset_defaults();
      test_lookup_resolution();
      test_arp_packets();
      test_random_traffic(9);
      test_random_traffic(84);
      test_random_traffic(0);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      mismatch_count += pending_results.size();
      $display("%0d items sent in %0d cycles, %0d packets dropped", items_sent, cycle_count,
               dropped_count);
      $display("results: %0d bindings, %0d requests, %0d replies, %0d alarms",
               kind_tally[KIND_BIND], kind_tally[KIND_REQ], kind_tally[KIND_REPLY],
               kind_tally[KIND_ALARM]);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
